>>> sv/crtr_pkg.sv
// Shared types, constants and step functions of the combined Tausworthe generator.
`timescale 1ns / 1ps
package crtr_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] SEED_MIX_ONE   = 32'hFEA09B9D;
  localparam logic [31:0] SEED_MIX_TWO   = 32'h9C129511;
  localparam logic [31:0] SEED_MIX_THREE = 32'h2512CFB8;
  localparam logic [31:0] MASK_ONE       = 32'hFFFFFFFE;
  localparam logic [31:0] MASK_TWO       = 32'hFFFFFFF8;
  localparam logic [31:0] MASK_THREE     = 32'hFFFFFFF0;

  // Divisor of the range mapping, 2^32 - 1, held in 33 bits.
  localparam logic [32:0] SPAN_DIVISOR   = 33'h0FFFFFFFF;

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  typedef struct packed {
    logic [31:0] one;
    logic [31:0] two;
    logic [31:0] three;
  } state_t;

  // One draw waiting for its range mapping.
  typedef struct packed {
    logic [31:0]        raw;
    logic signed [31:0] start;
    logic               neg;
    logic [31:0]        mag;
  } job_t;

  function automatic state_t advance(input state_t s);
    state_t n;
    n.one   = ((s.one & MASK_ONE) << 24) ^ ((s.one ^ (s.one << 7)) >> 7);
    n.two   = ((s.two & MASK_TWO) << 7) ^ ((s.two ^ (s.two << 2)) >> 22);
    n.three = ((s.three & MASK_THREE) << 11) ^ ((s.three ^ (s.three << 9)) >> 17);
    return n;
  endfunction

  // Mix the seed, self-correct each component, then take the warm-up step.
  function automatic state_t reseed(input logic [31:0] seed);
    state_t m;
    m.one   = (seed ^ SEED_MIX_ONE) & MASK_ONE;
    m.two   = (seed ^ SEED_MIX_TWO) & MASK_TWO;
    m.three = (seed ^ SEED_MIX_THREE) & MASK_THREE;
    m.one   = m.one ^ (((m.one << 7) ^ m.one) >> 31);
    m.two   = m.two ^ (((m.two << 2) ^ m.two) >> 29);
    m.three = m.three ^ (((m.three << 9) ^ m.three) >> 28);
    return advance(m);
  endfunction

endpackage

>>> sv/crtr_front.sv
// Front end: accepts words, keeps the generator state and queues draws.
`timescale 1ns / 1ps
module crtr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [31:0]         seed,
  input  logic signed [31:0]  range_start,
  input  logic signed [31:0]  range_end,
  input  logic                q_ready,
  output logic                push,
  output crtr_pkg::job_t      push_job
);

  crtr_pkg::state_t state;
  crtr_pkg::state_t stepped;
  logic             accept;
  logic [32:0]      span;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign push     = accept && (kind == crtr_pkg::KIND_DRAW);
  assign stepped  = crtr_pkg::advance(state);

  always_comb begin
    span           = {range_end[31], range_end} - {range_start[31], range_start};
    push_job.raw   = stepped.one ^ stepped.two ^ stepped.three;
    push_job.start = range_start;
    push_job.neg   = span[32];
    push_job.mag   = span[32] ? 32'(-span) : span[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crtr_pkg::reseed(32'h0);
    end else if (accept) begin
      if (kind == crtr_pkg::KIND_RESEED) begin
        state <= crtr_pkg::reseed(seed);
      end else begin
        state <= stepped;
      end
    end
  end

endmodule

>>> sv/crtr_queue.sv
// Short FIFO of pending draws between the front and the back end.
`timescale 1ns / 1ps
module crtr_queue #(
  parameter int DEPTH = crtr_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  crtr_pkg::job_t push_job,
  output logic           q_ready,
  output logic           q_valid,
  input  logic           pop,
  output crtr_pkg::job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  crtr_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign q_ready = (count != CW'(DEPTH));
  assign q_valid = (count != '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/crtr_back.sv
// Back end: scales the span by the raw word, divides by 2^32-1, adds the start and saturates.
`timescale 1ns / 1ps
module crtr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  crtr_pkg::job_t      pop_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         raw_value,
  output logic signed [31:0]  mapped_value
);

  localparam logic [32:0] SPAN_DIVISOR_X2 = {crtr_pkg::SPAN_DIVISOR[31:0], 1'b0};

  // Multiply stage.
  logic               m_valid;
  logic [63:0]        m_prod;
  logic [31:0]        m_raw;
  logic signed [31:0] m_start;
  logic               m_neg;
  // Quotient stage.
  logic               d_valid;
  logic [31:0]        d_quot;
  logic [31:0]        d_raw;
  logic signed [31:0] d_start;
  logic               d_neg;

  logic               o_free;
  logic               d_go;
  logic               d_free;
  logic               m_go;
  logic               m_free;
  logic [32:0]        fold;
  logic [31:0]        quot_next;
  logic signed [33:0] sum;
  logic signed [31:0] mapped_next;

  assign o_free = !out_valid || out_ready;
  assign d_go   = d_valid && o_free;
  assign d_free = !d_valid || d_go;
  assign m_go   = m_valid && d_free;
  assign m_free = !m_valid || m_go;
  assign pop    = q_valid && m_free;

  // p = H*2^32 + L = H*(2^32-1) + (H+L): fold the high half back in.
  always_comb begin
    fold = {1'b0, m_prod[63:32]} + {1'b0, m_prod[31:0]};
    if (fold >= {SPAN_DIVISOR_X2}) begin
      quot_next = m_prod[63:32] + 32'd2;
    end else if (fold >= crtr_pkg::SPAN_DIVISOR) begin
      quot_next = m_prod[63:32] + 32'd1;
    end else begin
      quot_next = m_prod[63:32];
    end
  end

  always_comb begin
    if (d_neg) begin
      sum = 34'(d_start) - $signed({2'b00, d_quot});
    end else begin
      sum = 34'(d_start) + $signed({2'b00, d_quot});
    end
    if (sum > 34'sh07FFFFFFF) begin
      mapped_next = 32'sh7FFFFFFF;
    end else if (sum < -34'sh080000000) begin
      mapped_next = -32'sh80000000;
    end else begin
      mapped_next = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_free) begin
        m_valid <= q_valid;
      end
      if (d_free) begin
        d_valid <= m_valid;
      end
      if (o_free) begin
        out_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_prod  <= 64'(pop_job.mag) * 64'(pop_job.raw);
      m_raw   <= pop_job.raw;
      m_start <= pop_job.start;
      m_neg   <= pop_job.neg;
    end
    if (m_go) begin
      d_quot  <= quot_next;
      d_raw   <= m_raw;
      d_start <= m_start;
      d_neg   <= m_neg;
    end
    if (d_go) begin
      raw_value    <= d_raw;
      mapped_value <= mapped_next;
    end
  end

endmodule

>>> sv/combined_tausworthe_rng_core.sv
// Top level of the three-component combined Tausworthe generator with range mapping.
`timescale 1ns / 1ps
// Three-component combined Tausworthe generator, shifts (24,7,7), (7,2,22) and
// (11,9,17). Each input word is either a draw (kind 0) or a reseed (kind 1).
// A draw advances all three components and returns their XOR as raw_value, plus
// mapped_value = range_start + trunc((range_end - range_start) * raw / (2^32-1)),
// computed exactly and clamped to signed 32 bits; a reversed range gives a value
// between the two ends. A reseed mixes the seed in, self-corrects the components
// and takes one silent warm-up step; it returns no word. After reset the state
// is that of a reseed with seed zero. One input word is taken every cycle while
// the pending-draw queue has room; an accepted draw passes through that queue,
// then the 32x32 multiply stage, the divide-by-2^32-1 fold stage and the output
// register. The queue holds QUEUE_DEPTH draws and the three back-end stages hold
// one each, so with an empty pipeline the input keeps flowing for QUEUE_DEPTH + 3
// draws while the output is stalled before in_ready drops.
module combined_tausworthe_rng_core #(
  parameter int QUEUE_DEPTH = crtr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [31:0]         seed,
  input  logic signed [31:0]  range_start,
  input  logic signed [31:0]  range_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         raw_value,
  output logic signed [31:0]  mapped_value
);

  logic           q_ready;
  logic           q_valid;
  logic           push;
  logic           pop;
  crtr_pkg::job_t push_job;
  crtr_pkg::job_t pop_job;

  // Front: hold the generator state, step or reseed it per accepted word, and
  // queue each draw together with its span.
  crtr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .seed        (seed),
    .range_start (range_start),
    .range_end   (range_end),
    .q_ready     (q_ready),
    .push        (push),
    .push_job    (push_job)
  );

  // Queue: decouple the generator from the mapping pipeline.
  crtr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .pop      (pop),
    .pop_job  (pop_job)
  );

  // Back: multiply, fold the division, add and clamp, then drive the output.
  crtr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .pop_job      (pop_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .raw_value    (raw_value),
    .mapped_value (mapped_value)
  );

  // A reseed never queues a draw.
  a_reseed_no_push : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == crtr_pkg::KIND_RESEED) |-> !push)
    else $error("reseed queued a draw");

  // Every accepted draw is queued.
  a_draw_pushes : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == crtr_pkg::KIND_DRAW) |-> push)
    else $error("accepted draw not queued");

  // The back end only takes from a non-empty queue.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

  // No result is shown right after reset.
  a_reset_quiet : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

>>> sim/tb_combined_tausworthe_rng_core.sv
// Self-checking testbench for the combined Tausworthe generator core.
`timescale 1ns / 1ps
module tb_combined_tausworthe_rng_core;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int INT_MIN = 32'sh8000_0000;
  localparam int INT_MAX = 32'sh7FFF_FFFF;

  // One draw result waiting to come out of the block.
  typedef struct {
    bit [31:0] raw;
    int        mapped;
  } draw_result_t;

  // Tracks the generator state on the side and keeps the draw results still owed.
  class rng_scoreboard;
    bit [31:0]    comp_one, comp_two, comp_three;
    draw_result_t owed_draws[$];
    int unsigned  errors, draws, reseeds, checked;

    function new();
      errors = 0;
      draws = 0;
      reseeds = 0;
      checked = 0;
      // The block comes out of reset as if reseeded with zero.
      load_seed(32'd0);
    endfunction

    // Advance all three shift registers; return the XOR of the new words.
    function bit [31:0] step_components();
      comp_one   = ((comp_one & 32'hFFFF_FFFE) << 24)
                   ^ ((comp_one ^ (comp_one << 7)) >> 7);
      comp_two   = ((comp_two & 32'hFFFF_FFF8) << 7)
                   ^ ((comp_two ^ (comp_two << 2)) >> 22);
      comp_three = ((comp_three & 32'hFFFF_FFF0) << 11)
                   ^ ((comp_three ^ (comp_three << 9)) >> 17);
      return comp_one ^ comp_two ^ comp_three;
    endfunction

    function void load_seed(bit [31:0] s);
      comp_one   = (s ^ 32'hFEA0_9B9D) & 32'hFFFF_FFFE;
      comp_two   = (s ^ 32'h9C12_9511) & 32'hFFFF_FFF8;
      comp_three = (s ^ 32'h2512_CFB8) & 32'hFFFF_FFF0;
      // Self-correct: fill each component's masked low bits from the top of its shift-XOR.
      comp_one   ^= ((comp_one << 7) ^ comp_one) >> 31;
      comp_two   ^= ((comp_two << 2) ^ comp_two) >> 29;
      comp_three ^= ((comp_three << 9) ^ comp_three) >> 28;
      // Drop one warm-up value.
      void'(step_components());
    endfunction

    // start + trunc(span * raw / (2^32 - 1)), exact, clamped to 32 bits.
    function int scale_into_range(int lo, int hi, bit [31:0] raw);
      longint          span, res;
      longint unsigned mag, prod, q;
      span = longint'(hi) - longint'(lo);
      mag  = (span < 0) ? -span : span;
      prod = mag * {32'd0, raw};
      q    = prod / 64'h0000_0000_FFFF_FFFF;
      res  = (span < 0) ? longint'(lo) - longint'(q) : longint'(lo) + longint'(q);
      if (res > longint'(INT_MAX)) res = INT_MAX;
      if (res < longint'(INT_MIN)) res = INT_MIN;
      return int'(res);
    endfunction

    function void note_word(bit k, bit [31:0] s, int lo, int hi);
      draw_result_t r;
      if (k == crtr_pkg::KIND_RESEED) begin
        load_seed(s);
        reseeds++;
      end else begin
        r.raw    = step_components();
        r.mapped = scale_into_range(lo, hi, r.raw);
        owed_draws.push_back(r);
        draws++;
      end
    endfunction

    function void check_word(bit [31:0] raw, int mapped);
      draw_result_t r;
      if (owed_draws.size() == 0) begin
        $error("unexpected result word raw_value=%08h mapped_value=%0d", raw, mapped);
        errors++;
        return;
      end
      r = owed_draws.pop_front();
      checked++;
      if (raw !== r.raw) begin
        $error("raw_value mismatch: expected %08h, actual %08h", r.raw, raw);
        errors++;
      end
      if (mapped !== r.mapped) begin
        $error("mapped_value mismatch: expected %0d, actual %0d", r.mapped, mapped);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = crtr_pkg::KIND_DRAW;
  logic [31:0]        seed = 32'd0;
  logic signed [31:0] range_start = 32'sd0;
  logic signed [31:0] range_end = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [31:0]        raw_value;
  logic signed [31:0] mapped_value;

  rng_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  int            stall_left = 0;
  bit            calm = 1'b0;   // when set, neither side idles

  combined_tausworthe_rng_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .seed        (seed),
    .range_start (range_start),
    .range_end   (range_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .raw_value   (raw_value),
    .mapped_value(mapped_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Range bound: extremes, values near zero, or anything at all.
  function automatic int pick_bound();
    case ($urandom_range(0, 9))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return 0;
      3: return -1;
      4, 5: return $urandom_range(0, 200) - 100;
      default: return int'($urandom);
    endcase
  endfunction

  // Seeds that cancel one mixing constant exercise the self-correction.
  function automatic bit [31:0] pick_seed();
    case ($urandom_range(0, 9))
      0: return 32'hFEA0_9B9D;
      1: return 32'h9C12_9511;
      2: return 32'h2512_CFB8;
      3: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: drop out_ready for random stretches.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  // Check results before noting new words; both look at pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_word(raw_value, mapped_value);
      if (in_valid && in_ready) sb.note_word(kind, seed, range_start, range_end);
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, sb.owed_draws.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it. Valid is lowered
  // only ahead of an idle gap, so a back-to-back word never toggles it.
  task automatic send_word(bit k, bit [31:0] s, int lo, int hi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    seed        <= s;
    range_start <= lo;
    range_end   <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic draw(int lo, int hi);
    send_word(crtr_pkg::KIND_DRAW, $urandom, lo, hi);
  endtask

  task automatic reseed_with(bit [31:0] s);
    send_word(crtr_pkg::KIND_RESEED, s, pick_bound(), pick_bound());
  endtask

  initial begin
    int lo, hi;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: range extremes, reversed and empty spans, ignored fields,
    // reseeds that zero a component before self-correction.
    draw(0, 0);
    draw(INT_MIN, INT_MAX);
    draw(INT_MAX, INT_MIN);
    draw(INT_MIN, INT_MIN);
    draw(INT_MAX, INT_MAX);
    draw(0, -1);
    draw(-1, 0);
    draw(0, INT_MAX);
    draw(INT_MIN, 0);
    draw(-5, 5);
    draw(100, -100);
    send_word(crtr_pkg::KIND_RESEED, 32'd0, INT_MAX, INT_MIN);
    draw(INT_MIN, INT_MAX);
    reseed_with(32'hFFFF_FFFF);
    draw(INT_MAX, INT_MIN);
    reseed_with(32'hFEA0_9B9D);
    draw(INT_MIN, INT_MAX);
    reseed_with(32'h9C12_9511);
    draw(1, -1);
    reseed_with(32'h2512_CFB8);
    reseed_with($urandom);
    draw(INT_MIN, INT_MAX);
    draw(INT_MAX, INT_MIN);

    // Random: mostly draws with assorted spans, reseeds mixed in.
    // Two windows run with both sides at full rate.
    for (int i = 0; i < 1900; i++) begin
      calm = (i >= 600 && i < 800) || (i >= 1400 && i < 1550);
      if ($urandom_range(0, 99) < 8) begin
        reseed_with(pick_seed());
      end else begin
        lo = pick_bound();
        hi = ($urandom_range(0, 99) < 15) ? lo : pick_bound();
        draw(lo, hi);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain, then give the pipeline a few cycles to show any stray word.
    while (sb.owed_draws.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d draws and %0d reseeds; %0d result words compared.",
             sb.draws, sb.reseeds, sb.checked);
    $display("Spans covered full, reversed, empty and near-zero ranges; %0d errors.",
             sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
sv/crtr_pkg.sv
sv/crtr_front.sv
sv/crtr_queue.sv
sv/crtr_back.sv
sv/combined_tausworthe_rng_core.sv
sim/tb_combined_tausworthe_rng_core.sv
